[rtl/lru_pkg.sv]
// Shared constants, payload types and control structs for the LRU page replacement block.
`default_nettype none
package lru_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int AGE_BITS  = 32;
  localparam int FAULT_BITS = 32;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int GRP_SIZE  = 4;
  localparam int GROUPS    = FRAMES / GRP_SIZE;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int AF_W       = 5;
  localparam logic [AF_W-1:0] AF_RESET = AF_W'(16);

  localparam logic [0:0] REG_ACTIVE_FRAMES = 1'b0;

  typedef struct packed {
    logic [15:0] page_number;
    logic        last_reference;
  } lru_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_count;
    logic        last_result;
  } lru_out_t;

  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } lru_cmd_t;

  typedef struct packed {
    logic out_full;
  } lru_sts_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_UPD  = 3'b100
  } lru_state_t;

endpackage
`default_nettype wire

[rtl/lru_ctrl.sv]
// Controller state machine: sequences accept, search and commit of each reference.
`default_nettype none
module lru_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            out_stall,
  input  wire lru_pkg::lru_sts_t sts,
  output lru_pkg::lru_cmd_t    cmd
);

  lru_pkg::lru_state_t state_r, state_nxt;
  logic slot_free;
  logic in_ready;

  always_comb begin
    slot_free  = !sts.out_full || !out_stall;
    cmd.commit = (state_r == lru_pkg::S_UPD) && slot_free;
    cmd.search = (state_r == lru_pkg::S_SRCH);
    in_ready   = (state_r == lru_pkg::S_IDLE) || cmd.commit;
    cmd.load   = in_valid && in_ready;
    in_stall   = !in_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lru_pkg::S_IDLE: begin
        if (cmd.load) state_nxt = lru_pkg::S_SRCH;
      end
      lru_pkg::S_SRCH: begin
        state_nxt = lru_pkg::S_UPD;
      end
      lru_pkg::S_UPD: begin
        if (cmd.load) state_nxt = lru_pkg::S_SRCH;
        else if (cmd.commit) state_nxt = lru_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lru_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lru_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/lru_dp.sv]
// Datapath: frame table, parallel search, registered age-max tree, update and result register.
`default_nettype none
module lru_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lru_pkg::lru_cmd_t         cmd,
  output lru_pkg::lru_sts_t              sts,
  input  wire lru_pkg::lru_in_t          in_data,
  input  wire logic [lru_pkg::AF_W-1:0]  active_frames,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output lru_pkg::lru_out_t              out_data
);

  localparam logic [lru_pkg::AGE_BITS-1:0]   AGE_MAX   = '1;
  localparam logic [lru_pkg::FAULT_BITS-1:0] FAULT_MAX = '1;

  logic [lru_pkg::PAGE_BITS-1:0]  page_r  [lru_pkg::FRAMES];
  logic [lru_pkg::AGE_BITS-1:0]   age_r   [lru_pkg::FRAMES];
  logic [lru_pkg::FRAMES-1:0]     valid_r;
  logic [lru_pkg::FAULT_BITS-1:0] faults_r;

  lru_pkg::lru_in_t item_r;

  logic                           hit_r, empty_r;
  logic [lru_pkg::IDX_W-1:0]      hit_idx_r, empty_idx_r;
  logic [lru_pkg::AGE_BITS-1:0]   grp_age_r [lru_pkg::GROUPS];
  logic [lru_pkg::IDX_W-1:0]      grp_idx_r [lru_pkg::GROUPS];

  logic                           out_valid_r;
  lru_pkg::lru_out_t              out_data_r;

  logic [lru_pkg::CNT_W-1:0]      used;
  logic [lru_pkg::FRAMES-1:0]     active;
  logic                           hit_c, empty_c;
  logic [lru_pkg::IDX_W-1:0]      hit_idx_c, empty_idx_c;
  logic [lru_pkg::AGE_BITS-1:0]   grp_age_c [lru_pkg::GROUPS];
  logic [lru_pkg::IDX_W-1:0]      grp_idx_c [lru_pkg::GROUPS];
  logic [lru_pkg::AGE_BITS-1:0]   cand_age  [lru_pkg::FRAMES];

  logic [lru_pkg::AGE_BITS-1:0]   best_age;
  logic [lru_pkg::IDX_W-1:0]      victim;
  logic [lru_pkg::IDX_W-1:0]      slot;
  logic                           evict;
  logic [lru_pkg::FAULT_BITS-1:0] faults_nxt;

  // clamp the active frame count to 1..FRAMES
  always_comb begin
    if (active_frames == '0) begin
      used = lru_pkg::CNT_W'(1);
    end else if (lru_pkg::CNT_W'(active_frames) > lru_pkg::CNT_W'(lru_pkg::FRAMES)) begin
      used = lru_pkg::CNT_W'(lru_pkg::FRAMES);
    end else begin
      used = lru_pkg::CNT_W'(active_frames);
    end
    for (int k = 0; k < lru_pkg::FRAMES; k++) begin
      active[k] = lru_pkg::CNT_W'(k) < used;
    end
  end

  // search: lowest hit, lowest empty, per-group age maximum
  always_comb begin
    hit_c       = 1'b0;
    empty_c     = 1'b0;
    hit_idx_c   = '0;
    empty_idx_c = '0;
    for (int k = lru_pkg::FRAMES - 1; k >= 0; k--) begin
      if (active[k] && valid_r[k] && (page_r[k] == item_r.page_number)) begin
        hit_c     = 1'b1;
        hit_idx_c = lru_pkg::IDX_W'(k);
      end
      if (active[k] && !valid_r[k]) begin
        empty_c     = 1'b1;
        empty_idx_c = lru_pkg::IDX_W'(k);
      end
    end
    for (int k = 0; k < lru_pkg::FRAMES; k++) begin
      cand_age[k] = active[k] ? age_r[k] : '0;
    end
    for (int g = 0; g < lru_pkg::GROUPS; g++) begin
      grp_age_c[g] = cand_age[g*lru_pkg::GRP_SIZE];
      grp_idx_c[g] = lru_pkg::IDX_W'(g*lru_pkg::GRP_SIZE);
      for (int j = 1; j < lru_pkg::GRP_SIZE; j++) begin
        if (cand_age[g*lru_pkg::GRP_SIZE+j] > grp_age_c[g]) begin
          grp_age_c[g] = cand_age[g*lru_pkg::GRP_SIZE+j];
          grp_idx_c[g] = lru_pkg::IDX_W'(g*lru_pkg::GRP_SIZE+j);
        end
      end
    end
  end

  // finish the max tree and pick the target frame
  always_comb begin
    best_age = grp_age_r[0];
    victim   = grp_idx_r[0];
    for (int g = 1; g < lru_pkg::GROUPS; g++) begin
      if (grp_age_r[g] > best_age) begin
        best_age = grp_age_r[g];
        victim   = grp_idx_r[g];
      end
    end
    evict = !hit_r && !empty_r;
    if (hit_r) slot = hit_idx_r;
    else if (empty_r) slot = empty_idx_r;
    else slot = victim;
    if (!hit_r && (faults_r != FAULT_MAX)) faults_nxt = faults_r + 1'b1;
    else faults_nxt = faults_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.search) begin
      hit_r       <= hit_c;
      empty_r     <= empty_c;
      hit_idx_r   <= hit_idx_c;
      empty_idx_r <= empty_idx_c;
      for (int g = 0; g < lru_pkg::GROUPS; g++) begin
        grp_age_r[g] <= grp_age_c[g];
        grp_idx_r[g] <= grp_idx_c[g];
      end
    end
    if (cmd.commit) begin
      out_data_r.hit           <= hit_r;
      out_data_r.frame_index   <= 4'(slot);
      out_data_r.evicted_valid <= evict;
      out_data_r.evicted_page  <= evict ? 16'(page_r[slot]) : '0;
      out_data_r.fault_count   <= 32'(faults_nxt);
      out_data_r.last_result   <= item_r.last_reference;
      if (!hit_r) page_r[slot] <= item_r.page_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < lru_pkg::FRAMES; k++) begin
        age_r[k] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        faults_r      <= faults_nxt;
        valid_r[slot] <= 1'b1;
        for (int k = 0; k < lru_pkg::FRAMES; k++) begin
          if (active[k]) begin
            if (lru_pkg::IDX_W'(k) == slot) age_r[k] <= '0;
            else if (valid_r[k] && (age_r[k] != AGE_MAX)) age_r[k] <= age_r[k] + 1'b1;
          end
        end
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign sts.out_full = out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule
`default_nettype wire

[rtl/lru_page_replacement_top.sv]
// A beat goes to item_r, then the search registers, then the output register.
// A new reference is taken only when idle or as the last commits; stalls when the
//   result is not taken. Stages: search, then max-tree and commit over the 16 frames.
// Reset (rst_n, synchronous, active low): all frames empty, ages and fault count zero,
//   active_frames back to 16, no result pending.
// Top level: APB configuration register, controller and datapath.
`default_nettype none
module lru_page_replacement_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lru_pkg::lru_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output lru_pkg::lru_out_t                    out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lru_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [lru_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lru_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  logic [lru_pkg::AF_W-1:0] active_frames_r;
  logic                     reg_sel;
  lru_pkg::lru_cmd_t        cmd;
  lru_pkg::lru_sts_t        sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lru_pkg::CFG_ADDR_W-1:2] == lru_pkg::REG_ACTIVE_FRAMES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_frames_r <= lru_pkg::AF_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      active_frames_r <= pwdata[lru_pkg::AF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) prdata[lru_pkg::AF_W-1:0] = active_frames_r;
  end

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lru_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data       (in_data),
    .active_frames (active_frames_r),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

[rtl/lru_chk.sv]
// Port-level checker for the LRU page replacement block and its bind.
`default_nettype none
module lru_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire lru_pkg::lru_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted during search");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.hit || !out_data.evicted_valid) |->
      !(out_data.hit && out_data.evicted_valid) &&
      (out_data.evicted_page == '0))
    else $error("eviction reported without a replacement");

endmodule

bind lru_page_replacement_top lru_chk u_lru_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[tb/tb_lru_page_replacement_top.sv]
// Testbench for the counter-based LRU page replacement block: predicted results vs. DUT output.
`timescale 1ns / 100ps
module tb_lru_page_replacement_top;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_REFS     = 165;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lru_pkg::lru_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lru_pkg::lru_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lru_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [lru_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [lru_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  lru_page_replacement_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predicted frame table
  logic [15:0] frame_page[lru_pkg::FRAMES];
  bit frame_used[lru_pkg::FRAMES];
  logic [31:0] frame_age[lru_pkg::FRAMES];
  logic [31:0] fault_total;
  logic [lru_pkg::AF_W-1:0] frames_setting;

  lru_pkg::lru_in_t page_refs[$];
  lru_pkg::lru_out_t access_results[$];
  int refs_queued = 0;
  int refs_taken = 0;
  int mismatches = 0;
  int hits_seen = 0;
  int faults_seen = 0;
  int evictions_seen = 0;
  int watchdog = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  bit in_beat = 1'b0;
  bit apb_done = 1'b0;
  logic [lru_pkg::CFG_DATA_W-1:0] apb_rdata;
  logic [15:0] page_pool[32];
  int pool_n = 1;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  function automatic int frames_in_use();
    if (frames_setting == 0)
      return 1;
    if (frames_setting > lru_pkg::FRAMES)
      return lru_pkg::FRAMES;
    return int'(frames_setting);
  endfunction

  function automatic lru_pkg::lru_out_t lru_access(input lru_pkg::lru_in_t req);
    lru_pkg::lru_out_t res;
    int n;
    int slot;
    bit found;
    bit empty_found;
    logic [31:0] oldest;
    res = '0;
    n = frames_in_use();
    slot = 0;
    found = 1'b0;
    empty_found = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (!found && frame_used[k] && frame_page[k] == req.page_number) begin
        slot = k;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (fault_total != '1)
        fault_total++;
      for (int k = 0; k < n; k++) begin
        if (!empty_found && !frame_used[k]) begin
          slot = k;
          empty_found = 1'b1;
        end
      end
      if (!empty_found) begin
        oldest = frame_age[0];
        slot = 0;
        for (int k = 1; k < n; k++) begin
          if (frame_age[k] > oldest) begin
            oldest = frame_age[k];
            slot = k;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page = frame_page[slot];
      end
      frame_page[slot] = req.page_number;
      frame_used[slot] = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      if (k == slot)
        frame_age[k] = '0;
      else if (frame_used[k] && frame_age[k] != '1)
        frame_age[k]++;
    end
    res.hit = found;
    res.frame_index = slot[3:0];
    res.fault_count = fault_total;
    res.last_result = req.last_reference;
    return res;
  endfunction

  // drive beats and stall at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_beat) begin
        if (page_refs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data <= page_refs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // sample beats at the rising edge
  always @(posedge clk) begin
    lru_pkg::lru_out_t want;
    in_beat <= rst_n && in_valid && !in_stall;
    apb_done <= psel && penable && pready;
    apb_rdata <= prdata;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        access_results.push_back(lru_access(in_data));
        refs_taken++;
      end
      if (out_valid && !out_stall) begin
        if (access_results.size() == 0) begin
          flag_mismatch("beat with no result pending", 32'(out_data.frame_index), '0);
        end else begin
          want = access_results.pop_front();
          if (want.hit)
            hits_seen++;
          else
            faults_seen++;
          if (want.evicted_valid)
            evictions_seen++;
          if (out_data.hit !== want.hit)
            flag_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
          if (out_data.frame_index !== want.frame_index)
            flag_mismatch("frame_index", 32'(out_data.frame_index), 32'(want.frame_index));
          if (out_data.evicted_valid !== want.evicted_valid)
            flag_mismatch("evicted_valid", 32'(out_data.evicted_valid),
                          32'(want.evicted_valid));
          if (out_data.evicted_page !== want.evicted_page)
            flag_mismatch("evicted_page", 32'(out_data.evicted_page), 32'(want.evicted_page));
          if (out_data.fault_count !== want.fault_count)
            flag_mismatch("fault_count", out_data.fault_count, want.fault_count);
          if (out_data.last_result !== want.last_result)
            flag_mismatch("last_result", 32'(out_data.last_result), 32'(want.last_result));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready)) begin
        watchdog <= 0;
      end else if (watchdog + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", access_results.size());
        $display("simulation failed");
        $finish;
      end else begin
        watchdog <= watchdog + 1;
      end
    end
  end

  task automatic queue_ref(input logic [15:0] page, input logic last);
    lru_pkg::lru_in_t req;
    req.page_number = page;
    req.last_reference = last;
    page_refs.push_back(req);
    refs_queued++;
  endtask

  task automatic drain();
    while (refs_taken != refs_queued || access_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_active_frames(input logic [lru_pkg::AF_W-1:0] count);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= lru_pkg::CFG_ADDR_W'(4 * int'(lru_pkg::REG_ACTIVE_FRAMES));
    pwdata <= lru_pkg::CFG_DATA_W'(count);
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_done);
    frames_setting = count;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_done);
    psel <= 1'b0;
    penable <= 1'b0;
    if (apb_rdata !== lru_pkg::CFG_DATA_W'(count))
      flag_mismatch("active_frames readback", apb_rdata, lru_pkg::CFG_DATA_W'(count));
  endtask

  function automatic logic [15:0] pick_page();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75)
      return page_pool[$urandom_range(pool_n - 1)];
    if (roll < 85)
      return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic set_idling(input int regime);
    case (regime)
      0: begin
        send_gap_pct = 26;
        stall_pct = 75;
      end
      1: begin
        send_gap_pct = 75;
        stall_pct = 26;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    logic [lru_pkg::AF_W-1:0] phase_frames[9];
    for (int k = 0; k < lru_pkg::FRAMES; k++) begin
      frame_page[k] = '0;
      frame_used[k] = 1'b0;
      frame_age[k] = '0;
    end
    fault_total = '0;
    frames_setting = lru_pkg::AF_RESET;
    phase_frames = '{5'd16, 5'd1, 5'd7, 5'd0, 5'd3, 5'd31, 5'd12, 5'd2, 5'd16};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    set_idling(0);
    queue_ref(16'h0000, 1'b0);
    queue_ref(16'hFFFF, 1'b1);
    queue_ref(16'h0000, 1'b0);
    drain();
    set_active_frames(5'd0);
    queue_ref(16'h1234, 1'b0);
    queue_ref(16'h0000, 1'b1);
    queue_ref(16'h0000, 1'b0);
    drain();
    set_active_frames(5'd2);
    queue_ref(16'hFFFF, 1'b0);
    queue_ref(16'h00AA, 1'b0);
    queue_ref(16'h5555, 1'b0);
    queue_ref(16'hAAAA, 1'b1);
    drain();
    set_active_frames(5'd31);
    queue_ref(16'h8000, 1'b0);
    queue_ref(16'h7FFF, 1'b0);
    queue_ref(16'h5555, 1'b0);
    drain();
    set_active_frames(5'd4);
    queue_ref(16'h0101, 1'b0);
    queue_ref(16'h0202, 1'b0);
    queue_ref(16'h0303, 1'b0);
    queue_ref(16'h0404, 1'b0);
    drain();
    // grow back: pages evicted while the set was shrunken miss again in the full set
    set_active_frames(5'd16);
    queue_ref(16'h8000, 1'b0);
    queue_ref(16'h7FFF, 1'b1);
    drain();

    for (int p = 0; p < 9; p++) begin
      set_idling(p / 3);
      set_active_frames(phase_frames[p]);
      pool_n = frames_in_use() + $urandom_range(4);
      for (int k = 0; k < pool_n; k++)
        page_pool[k] = 16'($urandom);
      for (int i = 0; i < PHASE_REFS; i++) begin
        queue_ref(pick_page(), $urandom_range(7) == 0);
        // hold the sender until the block has emptied
        if (i == PHASE_REFS / 2)
          drain();
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (access_results.size() != 0)
      flag_mismatch("results never delivered", access_results.size(), '0);
    $display("covered %0d references over 15 frame settings and three idling regimes",
             refs_taken);
    $display("saw %0d hits, %0d faults, %0d evictions", hits_seen, faults_seen,
             evictions_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
